### rtl/smpq_pkg.sv
// package for the stable min priority queue: operation codes and the
// control group that the top level broadcasts to every queue cell
// no dependencies
package smpq_pkg;

  // operation carried by one input item
  typedef enum logic {
    KIND_ENQUEUE = 1'b0,
    KIND_DEQUEUE = 1'b1
  } kind_t;

  // per-cycle command shared by all cells of the chain
  typedef struct packed {
    logic insert;   // accepted enqueue on a queue that is not full
    logic remove;   // accepted dequeue on a queue that is not empty
  } cell_ctl_t;

endpackage

### rtl/smpq_cell.sv
// one slot of the sorted chain: holds an entry, compares it with the
// incoming priority and trades entries with its two neighbors
// depends on smpq_pkg
module smpq_cell #(
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                      clk,
  input  smpq_pkg::cell_ctl_t       ctl,
  input  logic                      occupied,
  input  logic [VALUE_WIDTH-1:0]    new_value,
  input  logic [PRIORITY_WIDTH-1:0] new_priority,
  input  logic                      prev_keep,
  input  logic [VALUE_WIDTH-1:0]    prev_value,
  input  logic [PRIORITY_WIDTH-1:0] prev_priority,
  input  logic [VALUE_WIDTH-1:0]    next_value,
  input  logic [PRIORITY_WIDTH-1:0] next_priority,
  output logic                      keep,
  output logic [VALUE_WIDTH-1:0]    value,
  output logic [PRIORITY_WIDTH-1:0] priority_o
);

  logic [VALUE_WIDTH-1:0]    value_r;
  logic [VALUE_WIDTH-1:0]    value_nxt;
  logic [PRIORITY_WIDTH-1:0] priority_r;
  logic [PRIORITY_WIDTH-1:0] priority_nxt;

  // entry stays put on insert when it is stored and not above the new one
  assign keep = occupied && (priority_r <= new_priority);

  // select the next entry of this slot
  always_comb begin
    value_nxt    = value_r;
    priority_nxt = priority_r;
    priority if (ctl.insert) begin
      priority if (keep) begin
        value_nxt    = value_r;
        priority_nxt = priority_r;
      end else if (prev_keep) begin
        value_nxt    = new_value;
        priority_nxt = new_priority;
      end else begin
        value_nxt    = prev_value;
        priority_nxt = prev_priority;
      end
    end else if (ctl.remove) begin
      value_nxt    = next_value;
      priority_nxt = next_priority;
    end
  end

  // slot storage, no reset needed
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    priority_r <= priority_nxt;
  end

  assign value      = value_r;
  assign priority_o = priority_r;

endmodule

### rtl/stable_min_priority_queue_unit.sv
// top level of the stable min priority queue: chain of sorted cells,
// entry count and a two-deep result buffer
// depends on smpq_pkg and smpq_cell
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | kind, item_value, item_priority
//   out_    | output    | out_valid / out_stall | head_value, head_priority,
//           |           |                       | is_empty, entry_count, op_error
//
// every item is done by all cells at once: they compare against the new
// priority in parallel and shift one place toward or away from the head.
// the result is registered, via the skid register when out_ stalls.
// one item per cycle is taken as long as out_ drains; a result register
// plus one skid register absorb a stall, in_stall rises once both are full.
// rst_n (synchronous) empties the queue and the result buffer.
module stable_min_priority_queue_unit #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [VALUE_WIDTH-1:0]              in_item_value,
  input  logic [PRIORITY_WIDTH-1:0]           in_item_priority,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [VALUE_WIDTH-1:0]              out_head_value,
  output logic [PRIORITY_WIDTH-1:0]           out_head_priority,
  output logic                                out_is_empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_entry_count,
  output logic                                out_op_error
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = VALUE_WIDTH + PRIORITY_WIDTH + 1 + CW + 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic                      in_fire;
  logic                      out_fire;
  logic                      is_deq;
  logic                      full;
  logic                      empty;
  smpq_pkg::cell_ctl_t       ctl;
  logic                      op_err;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [VALUE_WIDTH-1:0]    head_value;
  logic [PRIORITY_WIDTH-1:0] head_priority;
  logic [RW-1:0]             result;
  logic [RW-1:0]             out_data_r;
  logic [RW-1:0]             skid_data_r;
  logic                      out_valid_r;
  logic                      skid_valid_r;

  logic [VALUE_WIDTH-1:0]    cell_value    [QUEUE_DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_priority [QUEUE_DEPTH];
  logic                      cell_keep     [QUEUE_DEPTH];

  // handshake
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  // operation decode and refusal
  assign is_deq     = (in_kind == smpq_pkg::KIND_DEQUEUE);
  assign full       = (count_r == FULL_COUNT);
  assign empty      = (count_r == '0);
  assign ctl.insert = in_fire && !is_deq && !full;
  assign ctl.remove = in_fire && is_deq && !empty;
  assign op_err     = is_deq ? empty : full;

  // entry count
  always_comb begin
    priority if (ctl.insert) count_nxt = count_r + CW'(1);
    else if (ctl.remove)     count_nxt = count_r - CW'(1);
    else                     count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // chain of cells, cell 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                      prev_keep;
    logic [VALUE_WIDTH-1:0]    prev_value;
    logic [PRIORITY_WIDTH-1:0] prev_priority;
    logic [VALUE_WIDTH-1:0]    next_value;
    logic [PRIORITY_WIDTH-1:0] next_priority;

    if (i == 0) begin : g_first
      assign prev_keep     = 1'b1;
      assign prev_value    = in_item_value;
      assign prev_priority = in_item_priority;
    end else begin : g_mid
      assign prev_keep     = cell_keep[i-1];
      assign prev_value    = cell_value[i-1];
      assign prev_priority = cell_priority[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_value    = cell_value[i];
      assign next_priority = cell_priority[i];
    end else begin : g_inner
      assign next_value    = cell_value[i+1];
      assign next_priority = cell_priority[i+1];
    end

    smpq_cell #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occupied     (CW'(i) < count_r),
      .new_value    (in_item_value),
      .new_priority (in_item_priority),
      .prev_keep    (prev_keep),
      .prev_value   (prev_value),
      .prev_priority(prev_priority),
      .next_value   (next_value),
      .next_priority(next_priority),
      .keep         (cell_keep[i]),
      .value        (cell_value[i]),
      .priority_o   (cell_priority[i])
    );
  end

  // head after the operation
  always_comb begin
    head_value    = cell_value[0];
    head_priority = cell_priority[0];
    priority if (count_nxt == '0) begin
      head_value    = '0;
      head_priority = '0;
    end else if (ctl.insert && !cell_keep[0]) begin
      head_value    = in_item_value;
      head_priority = in_item_priority;
    end else if (ctl.remove) begin
      head_value    = cell_value[1];
      head_priority = cell_priority[1];
    end
  end

  assign result = {head_value, head_priority, (count_nxt == '0), count_nxt, op_err};

  // result register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end
  end

  // result ports
  assign out_valid = out_valid_r;
  assign {out_head_value, out_head_priority, out_is_empty, out_entry_count, out_op_error} =
    out_data_r;

endmodule

### rtl/smpq_checker.sv
// port-level checks for the stable min priority queue unit
// depends on smpq_pkg; bound to stable_min_priority_queue_unit below
module smpq_checker #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_kind,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [VALUE_WIDTH-1:0]           out_head_value,
  input logic [PRIORITY_WIDTH-1:0]        out_head_priority,
  input logic                             out_is_empty,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] out_entry_count,
  input logic                             out_op_error
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_count) &&
      $stable(out_head_value))
    else $error("stalled result changed");

  // empty flag agrees with the count, and an empty queue shows a zero head
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)) &&
      (!out_is_empty || (out_head_value == '0 && out_head_priority == '0)))
    else $error("empty flag inconsistent with result");

  // count never exceeds the depth
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  // an accepted dequeue on an idle, empty queue is refused
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_is_empty && !in_stall && in_valid &&
      in_kind == smpq_pkg::KIND_DEQUEUE |=> out_valid && out_op_error && out_is_empty)
    else $error("dequeue on empty queue not refused");

  // the input side is open right after reset
  assert property (@(posedge clk) $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("busy after reset");

endmodule

bind stable_min_priority_queue_unit smpq_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .VALUE_WIDTH   (VALUE_WIDTH),
  .PRIORITY_WIDTH(PRIORITY_WIDTH)
) u_smpq_checker (.*);

### dv/tb_stable_min_priority_queue_unit.sv
// testbench for stable_min_priority_queue_unit: directed and random enqueue and
// dequeue traffic, each result checked against a sorted-list predictor in the bench
// depends on smpq_pkg and the rtl of stable_min_priority_queue_unit
module tb_stable_min_priority_queue_unit;

  localparam int QDEPTH = 16;
  localparam int VW     = 32;
  localparam int PW     = 16;
  localparam int CW     = $clog2(QDEPTH + 1);

  // one expected result: the queue as seen after an item
  typedef struct {
    logic [VW-1:0] head_value;
    logic [PW-1:0] head_priority;
    logic          is_empty;
    logic [CW-1:0] entry_count;
    logic          op_error;
  } head_report_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_kind = smpq_pkg::KIND_ENQUEUE;
  logic [VW-1:0] in_item_value = '0;
  logic [PW-1:0] in_item_priority = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VW-1:0] out_head_value;
  logic [PW-1:0] out_head_priority;
  logic          out_is_empty;
  logic [CW-1:0] out_entry_count;
  logic          out_op_error;

  // sorted copy of the queue contents, head in slot 0
  logic [VW-1:0] sorted_value [QDEPTH];
  logic [PW-1:0] sorted_priority [QDEPTH];
  int unsigned   sorted_count = 0;

  head_report_t  pending_heads[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int full_refusals = 0;
  int empty_refusals = 0;

  stable_min_priority_queue_unit #(
    .QUEUE_DEPTH   (QDEPTH),
    .VALUE_WIDTH   (VW),
    .PRIORITY_WIDTH(PW)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_head_value   (out_head_value),
    .out_head_priority(out_head_priority),
    .out_is_empty     (out_is_empty),
    .out_entry_count  (out_entry_count),
    .out_op_error     (out_op_error)
  );

  // clock
  always #2 clk = ~clk;

  // print one mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // apply one operation to the sorted copy and queue the expected head report
  task automatic update_sorted_queue(input smpq_pkg::kind_t kind, input logic [VW-1:0] value,
                                     input logic [PW-1:0] prio);
    head_report_t rep;
    int unsigned  pos;
    logic         refused;

    refused = 1'b0;
    if (kind == smpq_pkg::KIND_ENQUEUE) begin
      if (sorted_count >= QDEPTH) begin
        refused = 1'b1;
        full_refusals++;
      end else begin
        // new entry goes behind every entry of lower or equal priority
        pos = 0;
        while (pos < sorted_count && sorted_priority[pos] <= prio) pos++;
        for (int k = sorted_count; k > pos; k--) begin
          sorted_value[k] = sorted_value[k-1];
          sorted_priority[k] = sorted_priority[k-1];
        end
        sorted_value[pos] = value;
        sorted_priority[pos] = prio;
        sorted_count++;
      end
    end else begin
      if (sorted_count == 0) begin
        refused = 1'b1;
        empty_refusals++;
      end else begin
        for (int k = 1; k < sorted_count; k++) begin
          sorted_value[k-1] = sorted_value[k];
          sorted_priority[k-1] = sorted_priority[k];
        end
        sorted_count--;
      end
    end

    // head fields read as zero on an empty queue
    rep.is_empty      = (sorted_count == 0);
    rep.head_value    = rep.is_empty ? '0 : sorted_value[0];
    rep.head_priority = rep.is_empty ? '0 : sorted_priority[0];
    rep.entry_count   = sorted_count[CW-1:0];
    rep.op_error      = refused;
    pending_heads.push_back(rep);
  endtask

  // send one item, with a random gap first; returns right after acceptance
  task automatic send_item(input smpq_pkg::kind_t kind, input logic [VW-1:0] value,
                           input logic [PW-1:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_item_value    <= value;
    in_item_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    update_sorted_queue(kind, value, prio);
  endtask

  // hold the input idle until every expected result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_heads.size() != 0) @(posedge clk);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    head_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_heads.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = pending_heads.pop_front();
        results_checked++;
        if (out_head_value !== want.head_value)
          report_mismatch("head_value", out_head_value, want.head_value);
        if (out_head_priority !== want.head_priority)
          report_mismatch("head_priority", 32'(out_head_priority), 32'(want.head_priority));
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_is_empty), 32'(want.is_empty));
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_entry_count), 32'(want.entry_count));
        if (out_op_error !== want.op_error)
          report_mismatch("op_error", 32'(out_op_error), 32'(want.op_error));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // dequeue on an empty queue is refused and reports zero head fields
  task automatic test_dequeue_on_empty();
    send_item(smpq_pkg::KIND_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // equal priorities keep arrival order, lower priority goes ahead of the head
  task automatic test_ordering_and_ties();
    send_item(smpq_pkg::KIND_ENQUEUE, 32'hA5A5_0001, 16'd5);
    send_item(smpq_pkg::KIND_ENQUEUE, 32'hA5A5_0002, 16'd5);
    send_item(smpq_pkg::KIND_ENQUEUE, 32'h0000_0003, 16'd3);
    send_item(smpq_pkg::KIND_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(smpq_pkg::KIND_ENQUEUE, 32'h0000_0000, 16'h0000);
    send_item(smpq_pkg::KIND_DEQUEUE, 32'h0, 16'h0);
    send_item(smpq_pkg::KIND_DEQUEUE, 32'h5A5A_5A5A, 16'h1234);
  endtask

  // fill to capacity, then one more enqueue is dropped, then two dequeues
  task automatic test_fill_to_overflow();
    while (sorted_count < QDEPTH)
      send_item(smpq_pkg::KIND_ENQUEUE, $urandom, 16'($urandom_range(6)));
    send_item(smpq_pkg::KIND_ENQUEUE, 32'hDEAD_BEEF, 16'h0000);
    send_item(smpq_pkg::KIND_DEQUEUE, 32'h0, 16'h0);
    send_item(smpq_pkg::KIND_DEQUEUE, 32'h0, 16'h0);
    wait_for_drain();
  endtask

  // random traffic in bursts that lean toward filling or emptying the queue
  task automatic test_random_traffic(input int n_items, input int sender_idle,
                                     input int receiver_stall);
    int              enq_bias;
    int              burst_left;
    int              pick;
    smpq_pkg::kind_t kind;
    logic [VW-1:0]   value;
    logic [PW-1:0]   prio;

    idle_pct   = sender_idle;
    stall_pct  = receiver_stall;
    burst_left = 0;
    enq_bias   = 50;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        pick       = $urandom_range(2);
        enq_bias   = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
        burst_left = $urandom_range(40, 10);
      end
      burst_left--;
      kind = ($urandom_range(99) < enq_bias) ? smpq_pkg::KIND_ENQUEUE
                                              : smpq_pkg::KIND_DEQUEUE;
      // mostly a narrow priority range so ties are common
      pick = $urandom_range(9);
      if (pick < 6)       prio = 16'($urandom_range(7));
      else if (pick < 8)  prio = 16'($urandom);
      else if (pick == 8) prio = '0;
      else                prio = '1;
      pick = $urandom_range(19);
      value = (pick == 0) ? '0 : (pick == 1) ? '1 : VW'($urandom);
      send_item(kind, value, prio);
      // pause once mid-phase until the result path is empty
      if (i == n_items / 2) wait_for_drain();
    end
    wait_for_drain();
  endtask

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_dequeue_on_empty();
    test_ordering_and_ties();
    test_fill_to_overflow();
    test_random_traffic(325, 0, 0);
    test_random_traffic(325, 66, 0);
    test_random_traffic(325, 0, 66);
    test_random_traffic(325, 37, 37);

    // let any stray result show up before closing
    in_valid <= 1'b0;
    repeat (20) @(posedge clk);
    if (pending_heads.size() != 0)
      report_mismatch("results still outstanding", pending_heads.size(), 32'd0);

    $display("sent %0d items over four idle/stall mixes, %0d results checked",
             items_sent, results_checked);
    $display("refused enqueues on full: %0d, refused dequeues on empty: %0d",
             full_refusals, empty_refusals);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("run timed out");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/stable_min_priority_queue_unit.sv
rtl/smpq_checker.sv
dv/tb_stable_min_priority_queue_unit.sv
